### hdl/utf8rs_pkg.sv
// Shared types, constants and UTF-8 helper functions for the range splitter
package utf8rs_pkg;

	localparam logic [20:0] CP_MAX   = 21'h10FFFF;
	localparam int          STK_AW   = 3;
	localparam int          STK_DEPTH = 1 << STK_AW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ERR,
		ST_SEG,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic load;
		logic seg_init;
		logic step;
		logic emit;
		logic emit_bad;
		logic last;
		logic pop;
		logic next_seg;
	} ctl_cmd_t;

	typedef struct packed {
		logic bad_in;
		logic leaf;
		logic stk_empty;
		logic more;
		logic out_free;
	} ctl_sts_t;

	function automatic logic [1:0] enc_len(input logic [20:0] cp);
		if (cp <= 21'h7F)
			return 2'd0;
		else if (cp <= 21'h7FF)
			return 2'd1;
		else if (cp <= 21'hFFFF)
			return 2'd2;
		else
			return 2'd3;
	endfunction

	function automatic logic [20:0] len_max(input logic [1:0] len);
		case (len)
			2'd0:    return 21'h7F;
			2'd1:    return 21'h7FF;
			2'd2:    return 21'hFFFF;
			default: return CP_MAX;
		endcase
	endfunction

	function automatic logic [20:0] tail_mask(input logic [1:0] rem);
		case (rem)
			2'd1:    return 21'h3F;
			2'd2:    return 21'hFFF;
			2'd3:    return 21'h3FFFF;
			default: return 21'h0;
		endcase
	endfunction

	function automatic logic [7:0] code_unit(input logic [20:0] cp, input logic [1:0] pos,
						 input logic [1:0] len);
		logic [1:0] sh;
		sh = len - pos;
		if (pos == 2'd0) begin
			case (len)
				2'd0:    return {1'b0, cp[6:0]};
				2'd1:    return {3'b110, cp[10:6]};
				2'd2:    return {4'hE, cp[15:12]};
				default: return {5'b11110, cp[20:18]};
			endcase
		end
		case (sh)
			2'd0:    return {2'b10, cp[5:0]};
			2'd1:    return {2'b10, cp[11:6]};
			2'd2:    return {2'b10, cp[17:12]};
			default: return {2'b10, 3'b000, cp[20:18]};
		endcase
	endfunction

endpackage

### hdl/utf8rs_if.sv
// Channel interfaces: code point range in, byte-range sequence out
interface utf8rs_rng_if;
	logic        valid;
	logic        ready;
	logic [20:0] range_low;
	logic [20:0] range_high;
	modport source (output valid, range_low, range_high, input ready);
	modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface utf8rs_seq_if;
	logic       valid;
	logic       ready;
	logic [2:0] seq_length;
	logic [7:0] first_lo_byte;
	logic [7:0] first_hi_byte;
	logic [7:0] second_lo_byte;
	logic [7:0] second_hi_byte;
	logic [7:0] third_lo_byte;
	logic [7:0] third_hi_byte;
	logic [7:0] fourth_lo_byte;
	logic [7:0] fourth_hi_byte;
	logic       last_of_range;
	logic       bad_range;
	modport source (output valid, seq_length, first_lo_byte, first_hi_byte, second_lo_byte,
			second_hi_byte, third_lo_byte, third_hi_byte, fourth_lo_byte,
			fourth_hi_byte, last_of_range, bad_range, input ready);
	modport sink   (input valid, seq_length, first_lo_byte, first_hi_byte, second_lo_byte,
			second_hi_byte, third_lo_byte, third_hi_byte, fourth_lo_byte,
			fourth_hi_byte, last_of_range, bad_range, output ready);
endinterface

### hdl/utf8rs_ctrl.sv
// Split sequencer state machine
module utf8rs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rng_valid,
	output logic                rng_ready,
	input  utf8rs_pkg::ctl_sts_t sts,
	output utf8rs_pkg::ctl_cmd_t cmd
);

	utf8rs_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= utf8rs_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			utf8rs_pkg::ST_IDLE: begin
				if (rng_valid)
					state_nx = sts.bad_in ? utf8rs_pkg::ST_ERR : utf8rs_pkg::ST_SEG;
			end
			utf8rs_pkg::ST_ERR: begin
				if (sts.out_free)
					state_nx = utf8rs_pkg::ST_IDLE;
			end
			utf8rs_pkg::ST_SEG: state_nx = utf8rs_pkg::ST_WALK;
			utf8rs_pkg::ST_WALK: begin
				if (sts.leaf && sts.out_free && sts.stk_empty)
					state_nx = sts.more ? utf8rs_pkg::ST_SEG : utf8rs_pkg::ST_IDLE;
			end
			default: state_nx = utf8rs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		rng_ready = 1'b0;
		case (state_q)
			utf8rs_pkg::ST_IDLE: begin
				rng_ready = 1'b1;
				cmd.load = rng_valid;
			end
			utf8rs_pkg::ST_ERR: cmd.emit_bad = sts.out_free;
			utf8rs_pkg::ST_SEG: cmd.seg_init = 1'b1;
			utf8rs_pkg::ST_WALK: begin
				if (!sts.leaf) begin
					cmd.step = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.last     = sts.stk_empty && !sts.more;
					cmd.pop      = !sts.stk_empty;
					cmd.next_seg = sts.stk_empty && sts.more;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

### hdl/utf8rs_dp.sv
// Range registers, split stack and output word register
module utf8rs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [20:0]          range_low,
	input  logic [20:0]          range_high,
	input  utf8rs_pkg::ctl_cmd_t cmd,
	output utf8rs_pkg::ctl_sts_t sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [2:0]           seq_length,
	output logic [7:0]           byte_lo [4],
	output logic [7:0]           byte_hi [4],
	output logic                 last_of_range,
	output logic                 bad_range
);

	logic [20:0] seg_lo_q, top_hi_q, lo_q, hi_q;
	logic [1:0]  pos_q, len_q;
	logic        more_q;
	logic [20:0] stk_lo_q [utf8rs_pkg::STK_DEPTH];
	logic [20:0] stk_hi_q [utf8rs_pkg::STK_DEPTH];
	logic [1:0]  stk_pos_q [utf8rs_pkg::STK_DEPTH];
	logic [utf8rs_pkg::STK_AW:0]   sp_q;
	logic [utf8rs_pkg::STK_AW-1:0] push_idx, pop_idx;
	logic        out_valid_q;

	logic [1:0]  seg_len;
	logic        seg_more;
	logic [20:0] mask, floor_hi, ceil_lo;
	logic [7:0]  hu, lu;
	logic        descend;
	logic [20:0] up_lo, up_hi, dn_lo, dn_hi;

	assign push_idx = sp_q[utf8rs_pkg::STK_AW-1:0];
	assign pop_idx  = utf8rs_pkg::STK_AW'(sp_q - 1'b1);

	assign seg_len  = utf8rs_pkg::enc_len(seg_lo_q);
	assign seg_more = seg_len < utf8rs_pkg::enc_len(top_hi_q);

	assign hu       = utf8rs_pkg::code_unit(hi_q, pos_q, len_q);
	assign lu       = utf8rs_pkg::code_unit(lo_q, pos_q, len_q);
	assign mask     = utf8rs_pkg::tail_mask(len_q - pos_q);
	assign floor_hi = hi_q & ~mask;
	assign ceil_lo  = lo_q | mask;
	assign descend  = (hu == lu) || (((hi_q & mask) == mask) && ((lo_q & mask) == 21'h0));

	always_comb begin
		if ((hi_q & mask) != mask) begin
			up_lo = floor_hi;
			up_hi = hi_q;
			dn_lo = lo_q;
			dn_hi = floor_hi - 21'd1;
		end else begin
			up_lo = ceil_lo + 21'd1;
			up_hi = hi_q;
			dn_lo = lo_q;
			dn_hi = ceil_lo;
		end
	end

	assign sts.bad_in    = (range_low > range_high) || (range_high > utf8rs_pkg::CP_MAX);
	assign sts.leaf      = pos_q == len_q;
	assign sts.stk_empty = sp_q == '0;
	assign sts.more      = more_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.seg_init) begin
			sp_q <= '0;
		end else if (cmd.step && !descend) begin
			sp_q <= sp_q + 1'b1;
		end else if (cmd.pop) begin
			sp_q <= sp_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seg_lo_q <= range_low;
			top_hi_q <= range_high;
		end
		if (cmd.next_seg)
			seg_lo_q <= utf8rs_pkg::len_max(len_q) + 21'd1;
		if (cmd.seg_init) begin
			lo_q   <= seg_lo_q;
			hi_q   <= seg_more ? utf8rs_pkg::len_max(seg_len) : top_hi_q;
			more_q <= seg_more;
			len_q  <= seg_len;
			pos_q  <= 2'd0;
		end else if (cmd.step) begin
			if (descend) begin
				pos_q <= pos_q + 2'd1;
			end else begin
				lo_q                <= up_lo;
				hi_q                <= up_hi;
				stk_lo_q[push_idx]  <= dn_lo;
				stk_hi_q[push_idx]  <= dn_hi;
				stk_pos_q[push_idx] <= pos_q;
			end
		end else if (cmd.pop) begin
			lo_q  <= stk_lo_q[pop_idx];
			hi_q  <= stk_hi_q[pop_idx];
			pos_q <= stk_pos_q[pop_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit || cmd.emit_bad)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_bad) begin
			seq_length    <= 3'd0;
			last_of_range <= 1'b1;
			bad_range     <= 1'b1;
			for (int p = 0; p < 4; p++) begin
				byte_lo[p] <= 8'd0;
				byte_hi[p] <= 8'd0;
			end
		end else if (cmd.emit) begin
			seq_length    <= 3'(len_q) + 3'd1;
			last_of_range <= cmd.last;
			bad_range     <= 1'b0;
			for (int p = 0; p < 4; p++) begin
				byte_lo[p] <= (2'(p) <= len_q) ?
					utf8rs_pkg::code_unit(lo_q, 2'(p), len_q) : 8'd0;
				byte_hi[p] <= (2'(p) <= len_q) ?
					utf8rs_pkg::code_unit(hi_q, 2'(p), len_q) : 8'd0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/utf8_range_splitter.sv
// Top level of the UTF-8 code point range splitter
//
//  channel | modport | word
//  rng     | sink    | range_low, range_high
//  seq     | source  | seq_length, byte ranges, last_of_range, bad_range
//
// One range at a time; rng.ready is high only while idle.
// Each sequence is built by walking or splitting its byte positions, then an emit
// step; each encoded length opens with a segment set-up step. A range gives up to
// sixteen words.
// A bad range gives one word, registered from the error state once seq is free.
// A stalled seq holds the sequencer at the emit step. Reset clears control state only.
module utf8_range_splitter (
	input logic         clk,
	input logic         arst_n,
	utf8rs_rng_if.sink   rng,
	utf8rs_seq_if.source seq
);

	utf8rs_pkg::ctl_cmd_t cmd;
	utf8rs_pkg::ctl_sts_t sts;
	logic [7:0] byte_lo [4];
	logic [7:0] byte_hi [4];

	utf8rs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rng_valid (rng.valid),
		.rng_ready (rng.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	utf8rs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.range_low     (rng.range_low),
		.range_high    (rng.range_high),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (seq.ready),
		.out_valid     (seq.valid),
		.seq_length    (seq.seq_length),
		.byte_lo       (byte_lo),
		.byte_hi       (byte_hi),
		.last_of_range (seq.last_of_range),
		.bad_range     (seq.bad_range)
	);

	assign seq.first_lo_byte  = byte_lo[0];
	assign seq.first_hi_byte  = byte_hi[0];
	assign seq.second_lo_byte = byte_lo[1];
	assign seq.second_hi_byte = byte_hi[1];
	assign seq.third_lo_byte  = byte_lo[2];
	assign seq.third_hi_byte  = byte_hi[2];
	assign seq.fourth_lo_byte = byte_lo[3];
	assign seq.fourth_hi_byte = byte_hi[3];

endmodule

### hdl/utf8rs_chk.sv
// Port checker for the range splitter and its bind
module utf8rs_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rng_valid,
	input logic       rng_ready,
	input logic       seq_valid,
	input logic       seq_ready,
	input logic [2:0] seq_length,
	input logic       last_of_range,
	input logic       bad_range
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid && !seq_ready |=> seq_valid && $stable(seq_length))
		else $error("seq word dropped under stall");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid && bad_range |-> last_of_range && (seq_length == 3'd0))
		else $error("bad word malformed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid && !bad_range |-> (seq_length != 3'd0) && (seq_length <= 3'd4))
		else $error("sequence length out of range");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		rng_valid && rng_ready |=> !rng_ready)
		else $error("second range taken while busy");

endmodule

bind utf8_range_splitter utf8rs_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.rng_valid     (rng.valid),
	.rng_ready     (rng.ready),
	.seq_valid     (seq.valid),
	.seq_ready     (seq.ready),
	.seq_length    (seq.seq_length),
	.last_of_range (seq.last_of_range),
	.bad_range     (seq.bad_range)
);
